>>> hw/rtl/first_fit_block_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// First-fit block allocator: assertion macros
// Shared concurrent assertion forms, clocked and reset-gated by the caller.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// First-fit block allocator package
// Region geometry, run-table widths, status and operation codes, FSM states.
// ---------------------------------------------------------------------------
package ffba_pkg;

    // Region geometry
    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_SHIFT = 16;

    // Run-table entry: signed run length, positive free, negative allocated
    localparam int ENTRY_W = 12;
    localparam int ADDR_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    // Walk position: a block index plus one run span
    localparam int POS_W   = $clog2(NUM_BLOCKS + (2 ** (ENTRY_W - 1)));
    // Blocks needed by a request: (bytes >> shift) + 1
    localparam int DATA_W  = 32;
    localparam int NEED_W  = DATA_W - BLOCK_SHIFT + 1;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [NEED_W-1:0]  t_need;
    typedef logic [DATA_W-1:0]  t_data;

    localparam t_pos   NUM_BLOCKS_POS   = POS_W'(NUM_BLOCKS);
    localparam t_entry NUM_BLOCKS_ENTRY = ENTRY_W'(NUM_BLOCKS);
    localparam t_addr  LAST_BLOCK       = ADDR_W'(NUM_BLOCKS - 1);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_BADOFF   = 2'd2,
        ST_NOTALLOC = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_A_EVAL,
        S_A_SPLIT,
        S_F_EVAL,
        S_M_EVAL,
        S_F_WRITE,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/ffba_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered (read-first).
// ---------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/first_fit_block_allocator_unit.sv
// Steps: an accepted request enters START; one settled there goes straight to DONE, an
//   allocate walks runs in A_EVAL and writes a split in A_SPLIT, a free checks the head in
//   F_EVAL, examines following runs in M_EVAL and writes back in F_WRITE; DONE loads the result.
// One item at a time: o_stall stays high until DONE hands the result to the output register,
//   which waits while the result side stalls; the single RAM read port paces the walk at one run per cycle.
// Reset: synchronous, active low; a clearing pass over all NUM_BLOCKS entries follows, o_stall high.
// ---------------------------------------------------------------------------
// First-fit block allocator
// Run-length table in one RAM; first-fit walk on allocate, forward merge on free.
// ---------------------------------------------------------------------------
`include "first_fit_block_allocator_unit_macros.svh"

module first_fit_block_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_free_offset,
    input  logic        i_is_null,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_offset
);

    // State and datapath registers
    ffba_pkg::t_state  r_state, n_state;
    ffba_pkg::t_addr   r_clr, n_clr;
    logic              r_op, n_op;
    logic              r_nofit, n_nofit;
    logic              r_is_null, n_is_null;
    logic              r_badoff, n_badoff;
    ffba_pkg::t_pos    r_need, n_need;
    ffba_pkg::t_addr   r_idx, n_idx;
    ffba_pkg::t_pos    r_pos, n_pos;
    ffba_pkg::t_entry  r_len, n_len;
    ffba_pkg::t_entry  r_rem, n_rem;
    ffba_pkg::t_status r_res_status, n_res_status;
    ffba_pkg::t_data   r_res_offset, n_res_offset;
    logic              r_o_valid, n_o_valid;
    ffba_pkg::t_status r_o_status, n_o_status;
    ffba_pkg::t_data   r_o_offset, n_o_offset;

    // RAM port
    logic              ram_we;
    ffba_pkg::t_addr   ram_waddr;
    ffba_pkg::t_entry  ram_wdata;
    ffba_pkg::t_addr   ram_raddr;
    ffba_pkg::t_entry  ram_rdata;
    logic              rd_issue;

    // Decoded request and entry
    logic              accept;
    logic              out_free;
    ffba_pkg::t_need   need_full;
    logic              rd_neg;
    logic              rd_zero;
    logic              rd_free;
    ffba_pkg::t_entry  rd_mag;
    ffba_pkg::t_entry  rd_span;
    logic              alloc_fit;
    ffba_pkg::t_pos    walk_next;
    logic              walk_more;
    ffba_pkg::t_pos    split_pos;
    logic              split_ok;
    ffba_pkg::t_pos    free_end;
    logic              free_more;
    ffba_pkg::t_pos    merge_next;
    logic              merge_more;

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (ffba_pkg::NUM_BLOCKS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshakes
    assign o_stall  = (r_state != ffba_pkg::S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    // Request decode at accept
    assign need_full = ffba_pkg::t_need'(i_request_bytes >> ffba_pkg::BLOCK_SHIFT)
                     + ffba_pkg::t_need'(1);

    // Entry just read: magnitude, span and the walk/merge arithmetic
    always_comb begin
        rd_neg     = ram_rdata[ffba_pkg::ENTRY_W-1];
        rd_zero    = (ram_rdata == '0);
        rd_free    = !rd_neg && !rd_zero;
        rd_mag     = rd_neg ? (ffba_pkg::t_entry'(0) - ram_rdata) : ram_rdata;
        rd_span    = rd_zero ? ffba_pkg::t_entry'(1) : rd_mag;
        alloc_fit  = rd_free && (ffba_pkg::t_pos'(rd_mag) >= r_need);
        walk_next  = r_pos + ffba_pkg::t_pos'(rd_span);
        walk_more  = (walk_next < ffba_pkg::NUM_BLOCKS_POS);
        split_pos  = r_pos + r_need;
        split_ok   = (ffba_pkg::t_pos'(rd_mag) > r_need)
                   && (split_pos < ffba_pkg::NUM_BLOCKS_POS);
        free_end   = ffba_pkg::t_pos'(r_idx) + ffba_pkg::t_pos'(rd_mag);
        free_more  = (free_end < ffba_pkg::NUM_BLOCKS_POS);
        merge_next = r_pos + ffba_pkg::t_pos'(rd_mag);
        merge_more = (merge_next < ffba_pkg::NUM_BLOCKS_POS);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_CLEAR: begin
                if (r_clr == ffba_pkg::LAST_BLOCK) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            ffba_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ffba_pkg::S_START;
                end
            end
            ffba_pkg::S_START: begin
                if (r_op == ffba_pkg::OP_ALLOC) begin
                    n_state = r_nofit ? ffba_pkg::S_DONE : ffba_pkg::S_A_EVAL;
                end else if (r_is_null || r_badoff) begin
                    n_state = ffba_pkg::S_DONE;
                end else begin
                    n_state = ffba_pkg::S_F_EVAL;
                end
            end
            ffba_pkg::S_A_EVAL: begin
                if (alloc_fit) begin
                    n_state = split_ok ? ffba_pkg::S_A_SPLIT : ffba_pkg::S_DONE;
                end else if (!walk_more) begin
                    n_state = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_A_SPLIT: begin
                n_state = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_F_EVAL: begin
                if (!rd_neg) begin
                    n_state = ffba_pkg::S_DONE;
                end else if (free_more) begin
                    n_state = ffba_pkg::S_M_EVAL;
                end else begin
                    n_state = ffba_pkg::S_F_WRITE;
                end
            end
            ffba_pkg::S_M_EVAL: begin
                if (!rd_free || !merge_more) begin
                    n_state = ffba_pkg::S_F_WRITE;
                end
            end
            ffba_pkg::S_F_WRITE: begin
                n_state = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffba_pkg::S_CLEAR;
            end
        endcase
    end

    // Datapath, RAM controls and result register
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_nofit      = r_nofit;
        n_is_null    = r_is_null;
        n_badoff     = r_badoff;
        n_need       = r_need;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_len        = r_len;
        n_rem        = r_rem;
        n_res_status = r_res_status;
        n_res_offset = r_res_offset;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = r_len;
        ram_raddr    = r_idx;
        rd_issue     = 1'b0;

        unique case (r_state)
            // one entry per cycle: block 0 holds the whole region, the rest zero
            ffba_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = (r_clr == '0) ? ffba_pkg::NUM_BLOCKS_ENTRY : '0;
                n_clr     = r_clr + ffba_pkg::t_addr'(1);
            end
            ffba_pkg::S_IDLE: begin
                if (accept) begin
                    n_op      = i_operation;
                    n_is_null = i_is_null;
                    n_nofit   = (32'(need_full) > 32'(ffba_pkg::NUM_BLOCKS));
                    n_need    = ffba_pkg::t_pos'(need_full);
                    n_badoff  = (i_free_offset[ffba_pkg::BLOCK_SHIFT-1:0] != '0)
                             || ((i_free_offset >> ffba_pkg::BLOCK_SHIFT)
                                 >= 32'(ffba_pkg::NUM_BLOCKS));
                    n_idx     = ffba_pkg::t_addr'(i_free_offset >> ffba_pkg::BLOCK_SHIFT);
                end
            end
            ffba_pkg::S_START: begin
                n_res_status = ffba_pkg::ST_OK;
                n_res_offset = '0;
                if (r_op == ffba_pkg::OP_ALLOC) begin
                    if (r_nofit) begin
                        n_res_status = ffba_pkg::ST_NOFIT;
                    end else begin
                        ram_raddr = '0;
                        rd_issue  = 1'b1;
                        n_pos     = '0;
                    end
                end else if (r_is_null) begin
                    n_res_status = ffba_pkg::ST_OK;
                end else if (r_badoff) begin
                    n_res_status = ffba_pkg::ST_BADOFF;
                end else begin
                    ram_raddr = r_idx;
                    rd_issue  = 1'b1;
                end
            end
            // first-fit walk, one run a cycle
            ffba_pkg::S_A_EVAL: begin
                if (alloc_fit) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_pos[ffba_pkg::ADDR_W-1:0];
                    ram_wdata    = ffba_pkg::t_entry'(ffba_pkg::t_pos'(0) - r_need);
                    n_rem        = ffba_pkg::t_entry'(ffba_pkg::t_pos'(rd_mag) - r_need);
                    n_pos        = split_pos;
                    n_res_status = ffba_pkg::ST_OK;
                    n_res_offset = ffba_pkg::t_data'(r_pos) << ffba_pkg::BLOCK_SHIFT;
                end else if (walk_more) begin
                    ram_raddr = walk_next[ffba_pkg::ADDR_W-1:0];
                    rd_issue  = 1'b1;
                    n_pos     = walk_next;
                end else begin
                    n_res_status = ffba_pkg::ST_NOFIT;
                end
            end
            // remainder of the split run stays free
            ffba_pkg::S_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ffba_pkg::ADDR_W-1:0];
                ram_wdata = r_rem;
            end
            ffba_pkg::S_F_EVAL: begin
                if (!rd_neg) begin
                    n_res_status = ffba_pkg::ST_NOTALLOC;
                end else begin
                    n_len = rd_mag;
                    n_pos = free_end;
                    if (free_more) begin
                        ram_raddr = free_end[ffba_pkg::ADDR_W-1:0];
                        rd_issue  = 1'b1;
                    end
                end
            end
            // absorb following free runs; the head is written once at the end
            ffba_pkg::S_M_EVAL: begin
                if (rd_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[ffba_pkg::ADDR_W-1:0];
                    ram_wdata = '0;
                    n_len     = r_len + rd_mag;
                    n_pos     = merge_next;
                    if (merge_more) begin
                        ram_raddr = merge_next[ffba_pkg::ADDR_W-1:0];
                        rd_issue  = 1'b1;
                    end
                end
            end
            ffba_pkg::S_F_WRITE: begin
                ram_we       = 1'b1;
                ram_waddr    = r_idx;
                ram_wdata    = r_len;
                n_res_status = ffba_pkg::ST_OK;
            end
            ffba_pkg::S_DONE: begin
                rd_issue = 1'b0;
            end
            default: begin
                rd_issue = 1'b0;
            end
        endcase
    end

    // Output register: loaded from DONE, emptied when taken
    always_comb begin
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_offset = r_o_offset;
        if (r_state == ffba_pkg::S_DONE && out_free) begin
            n_o_valid  = 1'b1;
            n_o_status = r_res_status;
            n_o_offset = r_res_offset;
        end else if (!i_stall) begin
            n_o_valid  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffba_pkg::S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_nofit      <= n_nofit;
        r_is_null    <= n_is_null;
        r_badoff     <= n_badoff;
        r_need       <= n_need;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_len        <= n_len;
        r_rem        <= n_rem;
        r_res_status <= n_res_status;
        r_res_offset <= n_res_offset;
        r_o_status   <= n_o_status;
        r_o_offset   <= n_o_offset;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_granted_offset = r_o_offset;

    // Checks
    `FFBA_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, ram_we && rd_issue,
        ram_waddr != ram_raddr, "run table read and write hit the same entry")
    `FFBA_ASSERT_SAME(a_walk_in_range, i_clk, i_rst_n, r_state == ffba_pkg::S_A_EVAL,
        r_pos < ffba_pkg::NUM_BLOCKS_POS, "allocate walk left the region")
    `FFBA_ASSERT_SAME(a_merge_bounded, i_clk, i_rst_n,
        r_state == ffba_pkg::S_M_EVAL || r_state == ffba_pkg::S_F_WRITE,
        r_len <= ffba_pkg::NUM_BLOCKS_ENTRY, "merged run longer than the region")
    `FFBA_ASSERT_SAME(a_error_no_offset, i_clk, i_rst_n,
        r_o_valid && (r_o_status != ffba_pkg::ST_OK), r_o_offset == '0,
        "failed item carries an offset")
    `FFBA_ASSERT_NEXT(a_split_then_done, i_clk, i_rst_n, r_state == ffba_pkg::S_A_SPLIT,
        r_state == ffba_pkg::S_DONE && r_res_status == ffba_pkg::ST_OK,
        "split did not finish as a grant")

endmodule
